// ===== hdl/pcg32_bounded_random_generator_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the bounded PCG32 generator.
// ---------------------------------------------------------------------------
`ifndef PCG32_BOUNDED_RANDOM_GENERATOR_DEFINES_SVH
`define PCG32_BOUNDED_RANDOM_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold in every cycle outside reset.
`define PCG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define PCG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCG_ASSERT(lbl, clk, rstn, prop, msg)
`define PCG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hdl/pcg32b_pkg.sv =====
// ---------------------------------------------------------------------------
// pcg32b_pkg
// Types, constants and helper functions shared by the generator modules.
// ---------------------------------------------------------------------------
package pcg32b_pkg;

    localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;
    localparam logic [63:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SM_MIX1  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] SM_MIX2  = 64'h94D0_49BB_1331_11EB;

    localparam logic [1:0] OP_RAW    = 2'd0;
    localparam logic [1:0] OP_URANGE = 2'd1;
    localparam logic [1:0] OP_SRANGE = 2'd2;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_SEED_X,
        CMD_MUL_SM1,
        CMD_MUL_SM2,
        CMD_SAVE_START,
        CMD_SAVE_INC,
        CMD_SEED_STATE,
        CMD_LOAD_REQ,
        CMD_MOD_LIMIT,
        CMD_SAVE_LIMIT,
        CMD_MUL_LCG,
        CMD_LCG_UPDATE,
        CMD_MOD_DRAW,
        CMD_EMIT
    } cmd_t;

    typedef enum logic [4:0] {
        ST_SEED_X,
        ST_SM_A,
        ST_SM_A_WAIT,
        ST_SM_B,
        ST_SM_B_WAIT,
        ST_SAVE_START,
        ST_SAVE_INC,
        ST_SEED_STATE,
        ST_IDLE,
        ST_DECODE,
        ST_LIMIT_WAIT,
        ST_LIMIT_SAVE,
        ST_DRAW,
        ST_DRAW_WAIT,
        ST_DRAW_UPD,
        ST_MOD,
        ST_MOD_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic mul_done;
        logic mod_done;
        logic raw;
        logic bad;
        logic draw_ok;
    } dp_status_t;

    // XSH-RR output permutation of the old LCG state.
    function automatic logic [31:0] xsh_rr(input logic [63:0] old);
        logic [63:0] t;
        logic [31:0] xs;
        logic [4:0]  rot;
        logic [63:0] dbl;
        t   = old ^ (old >> 18);
        xs  = t[58:27];
        rot = old[63:59];
        dbl = {xs, xs} >> rot;
        return dbl[31:0];
    endfunction

endpackage

// ===== hdl/pcg32_bounded_random_generator.sv =====
// ---------------------------------------------------------------------------
// pcg32_bounded_random_generator
// PCG32 XSH-RR generator with raw, unsigned-range and signed-range requests.
// ---------------------------------------------------------------------------
// Usage:
//   A request enters on the s_ stream: s_tuser is the opcode (raw word,
//   unsigned range, signed 16-bit range), s_tdata carries the bounds. One
//   result leaves on the m_ stream: m_tdata is the value, m_tuser flags an
//   empty range (value then 0). The seed register sits on the APB port at
//   byte address 0; writing it reseeds the generator.
//   Requests are served one at a time. A raw word needs one pass through
//   the 64-bit multiply, built on one 32x32 multiplier. A range request
//   passes twice through the bit-serial remainder unit and draws again for
//   each rejected draw. An empty range goes from decode straight to the
//   result. The next request can be taken as soon as the result is
//   registered, unless a reseed is pending. After reset and after a seed
//   write the block reseeds with s_tready low. The next request is accepted
//   while a result waits; a stalled receiver holds the block at the end of
//   that one.
// ---------------------------------------------------------------------------
`include "pcg32_bounded_random_generator_defines.svh"

module pcg32_bounded_random_generator
    import pcg32b_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] low_bound, [63:32] high_bound
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic        m_tuser    // [0] bad_range
);

    logic        cfg_wr;
    logic [63:0] seed_value;
    dp_status_t  stat;
    cmd_t        cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[3];
    assign prdata = paddr[3] ? 64'h0 : seed_value;

    pcg32b_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_wr),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pcg32b_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_wr),
        .cfg_wdata (pwdata),
        .cfg_rdata (seed_value),
        .req_data  (s_tdata),
        .req_op    (s_tuser),
        .res_value (m_tdata),
        .res_bad   (m_tuser)
    );

    `PCG_ASSERT(a_bad_zero, aclk, aresetn, !(m_tvalid && m_tuser) || (m_tdata == 32'h0), "empty-range result carries a nonzero value")
    `PCG_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request accepted while another is in progress")
    `PCG_ASSERT_NEXT(a_reseed_blocks, aclk, aresetn, cfg_wr, !s_tready, "request accepted before reseed after seed write")

endmodule

// ===== hdl/pcg32b_mul.sv =====
// ---------------------------------------------------------------------------
// pcg32b_mul
// 64x64 multiplier, low 64 bits of the product, built from one shared
// 32x32 multiplier over three partial products.
// ---------------------------------------------------------------------------
module pcg32b_mul
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);

    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] pp_reg, pp_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  ph_reg, ph_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] ma, mb;

    always_comb begin
        case (ph_reg)
            2'd0: begin
                ma = a_reg[31:0];
                mb = b_reg[31:0];
            end
            2'd1: begin
                ma = a_reg[63:32];
                mb = b_reg[31:0];
            end
            default: begin
                ma = a_reg[31:0];
                mb = b_reg[63:32];
            end
        endcase
    end

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        pp_next   = pp_reg;
        acc_next  = acc_reg;
        ph_next   = ph_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = a;
            b_next    = b;
            ph_next   = 2'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            pp_next = 64'(ma) * 64'(mb);
            ph_next = ph_reg + 2'd1;
            case (ph_reg)
                2'd0:    acc_next = acc_reg;
                2'd1:    acc_next = pp_reg;
                default: acc_next = acc_reg + {pp_reg[31:0], 32'h0};
            endcase
            if (ph_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            ph_reg   <= ph_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

// ===== hdl/pcg32b_mod.sv =====
// ---------------------------------------------------------------------------
// pcg32b_mod
// 32-bit remainder unit, restoring division at one bit per cycle.
// ---------------------------------------------------------------------------
module pcg32b_mod
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] rem
);

    logic [31:0] dvd_reg, dvd_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [31:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {rem_reg, dvd_reg[31]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = 32'h0;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // Subtract when the shifted remainder reaches the divisor.
            rem_next = diff[32] ? shifted[31:0] : diff[31:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 5'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== hdl/pcg32b_datapath.sv =====
// ---------------------------------------------------------------------------
// pcg32b_datapath
// Generator state, seeding arithmetic, request registers and result
// register, driven one command per cycle by the controller.
// ---------------------------------------------------------------------------
module pcg32b_datapath
    import pcg32b_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output dp_status_t  stat,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    output logic [63:0] cfg_rdata,
    input  logic [63:0] req_data,
    input  logic [1:0]  req_op,
    output logic [31:0] res_value,
    output logic        res_bad
);

    logic [63:0] seed_reg, seed_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] state_reg, state_next;
    logic [63:0] inc_reg, inc_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] span_reg, span_next;
    logic [31:0] limit_reg, limit_next;
    logic        raw_reg, raw_next;
    logic        bad_reg, bad_next;
    logic [31:0] value_reg, value_next;
    logic        flag_reg, flag_next;

    logic        mul_start, mul_done;
    logic [63:0] mul_a, mul_b, mul_p;
    logic        mod_start, mod_done;
    logic [31:0] mod_dvd, mod_rem;
    logic [63:0] mix;
    logic [31:0] req_lo, req_hi, slo, shi;

    assign mix = mul_p ^ (mul_p >> 31);
    assign req_lo = req_data[31:0];
    assign req_hi = req_data[63:32];
    assign slo = {{16{req_data[15]}}, req_data[15:0]};
    assign shi = {{16{req_data[47]}}, req_data[47:32]};

    always_comb begin
        mul_start = 1'b1;
        mul_a     = state_reg;
        mul_b     = PCG_MULT;
        case (cmd)
            CMD_MUL_SM1: begin
                mul_a = x_reg ^ (x_reg >> 30);
                mul_b = SM_MIX1;
            end
            CMD_MUL_SM2: begin
                mul_a = mul_p ^ (mul_p >> 27);
                mul_b = SM_MIX2;
            end
            CMD_MUL_LCG: mul_start = 1'b1;
            default:     mul_start = 1'b0;
        endcase
    end

    assign mod_start = (cmd == CMD_MOD_LIMIT) || (cmd == CMD_MOD_DRAW);
    assign mod_dvd   = (cmd == CMD_MOD_LIMIT) ? (32'h0 - span_reg) : word_reg;

    pcg32b_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    pcg32b_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (mod_dvd),
        .divisor  (span_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_comb begin
        seed_next  = cfg_we ? cfg_wdata : seed_reg;
        x_next     = x_reg;
        state_next = state_reg;
        inc_next   = inc_reg;
        word_next  = word_reg;
        lo_next    = lo_reg;
        span_next  = span_reg;
        limit_next = limit_reg;
        raw_next   = raw_reg;
        bad_next   = bad_reg;
        value_next = value_reg;
        flag_next  = flag_reg;
        case (cmd)
            CMD_SEED_X: x_next = seed_reg + SM_GAMMA;
            CMD_SAVE_START: begin
                state_next = mix;
                x_next     = x_reg + SM_GAMMA;
            end
            CMD_SAVE_INC:   inc_next   = {mix[62:0], 1'b1};
            CMD_SEED_STATE: state_next = state_reg + inc_reg;
            CMD_LOAD_REQ: begin
                case (req_op)
                    OP_URANGE: begin
                        raw_next  = 1'b0;
                        bad_next  = !(req_lo < req_hi);
                        lo_next   = req_lo;
                        span_next = req_hi - req_lo;
                    end
                    OP_SRANGE: begin
                        raw_next  = 1'b0;
                        bad_next  = !($signed(slo) < $signed(shi));
                        lo_next   = slo;
                        span_next = shi - slo;
                    end
                    default: begin
                        raw_next = 1'b1;
                        bad_next = 1'b0;
                    end
                endcase
            end
            CMD_SAVE_LIMIT: limit_next = mod_rem;
            CMD_MUL_LCG:    word_next  = xsh_rr(state_reg);
            CMD_LCG_UPDATE: state_next = mul_p + inc_reg;
            CMD_EMIT: begin
                flag_next = bad_reg;
                if (bad_reg) begin
                    value_next = 32'h0;
                end else if (raw_reg) begin
                    value_next = word_reg;
                end else begin
                    value_next = lo_reg + mod_rem;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 64'h0;
        end else begin
            seed_reg <= seed_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        state_reg <= state_next;
        inc_reg   <= inc_next;
        word_reg  <= word_next;
        lo_reg    <= lo_next;
        span_reg  <= span_next;
        limit_reg <= limit_next;
        raw_reg   <= raw_next;
        bad_reg   <= bad_next;
        value_reg <= value_next;
        flag_reg  <= flag_next;
    end

    assign stat.mul_done = mul_done;
    assign stat.mod_done = mod_done;
    assign stat.raw      = raw_reg;
    assign stat.bad      = bad_reg;
    assign stat.draw_ok  = (word_reg >= limit_reg);

    assign cfg_rdata = seed_reg;
    assign res_value = value_reg;
    assign res_bad   = flag_reg;

endmodule

// ===== hdl/pcg32b_ctrl.sv =====
// ---------------------------------------------------------------------------
// pcg32b_ctrl
// Controller: sequences seeding, request decode, rejection draws and the
// result handshake.
// ---------------------------------------------------------------------------
module pcg32b_ctrl
    import pcg32b_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;
    logic   pass_reg, pass_next;
    logic   seeding_reg, seeding_next;
    logic   mvalid_reg, mvalid_next;
    logic   out_free;

    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        seeding_next = seeding_reg;
        pend_next    = pend_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        cmd          = CMD_NOP;
        s_tready     = 1'b0;
        case (state_reg)
            ST_SEED_X: begin
                cmd          = CMD_SEED_X;
                pend_next    = 1'b0;
                pass_next    = 1'b0;
                seeding_next = 1'b1;
                state_next   = ST_SM_A;
            end
            ST_SM_A: begin
                cmd        = CMD_MUL_SM1;
                state_next = ST_SM_A_WAIT;
            end
            ST_SM_A_WAIT: begin
                if (stat.mul_done) begin
                    state_next = ST_SM_B;
                end
            end
            ST_SM_B: begin
                cmd        = CMD_MUL_SM2;
                state_next = ST_SM_B_WAIT;
            end
            ST_SM_B_WAIT: begin
                if (stat.mul_done) begin
                    state_next = pass_reg ? ST_SAVE_INC : ST_SAVE_START;
                end
            end
            ST_SAVE_START: begin
                cmd        = CMD_SAVE_START;
                pass_next  = 1'b1;
                state_next = ST_SM_A;
            end
            ST_SAVE_INC: begin
                cmd        = CMD_SAVE_INC;
                state_next = ST_SEED_STATE;
            end
            ST_SEED_STATE: begin
                cmd        = CMD_SEED_STATE;
                state_next = ST_DRAW;
            end
            ST_IDLE: begin
                s_tready = !pend_reg;
                if (pend_reg) begin
                    state_next = ST_SEED_X;
                end else if (s_tvalid) begin
                    cmd        = CMD_LOAD_REQ;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (stat.bad) begin
                    state_next = ST_EMIT;
                end else if (stat.raw) begin
                    state_next = ST_DRAW;
                end else begin
                    cmd        = CMD_MOD_LIMIT;
                    state_next = ST_LIMIT_WAIT;
                end
            end
            ST_LIMIT_WAIT: begin
                if (stat.mod_done) begin
                    state_next = ST_LIMIT_SAVE;
                end
            end
            ST_LIMIT_SAVE: begin
                cmd        = CMD_SAVE_LIMIT;
                state_next = ST_DRAW;
            end
            ST_DRAW: begin
                cmd        = CMD_MUL_LCG;
                state_next = ST_DRAW_WAIT;
            end
            ST_DRAW_WAIT: begin
                if (stat.mul_done) begin
                    state_next = ST_DRAW_UPD;
                end
            end
            ST_DRAW_UPD: begin
                cmd = CMD_LCG_UPDATE;
                if (seeding_reg) begin
                    seeding_next = 1'b0;
                    state_next   = ST_IDLE;
                end else if (stat.raw) begin
                    state_next = ST_EMIT;
                end else if (stat.draw_ok) begin
                    state_next = ST_MOD;
                end else begin
                    // below the rejection threshold: draw again
                    state_next = ST_DRAW;
                end
            end
            ST_MOD: begin
                cmd        = CMD_MOD_DRAW;
                state_next = ST_MOD_WAIT;
            end
            ST_MOD_WAIT: begin
                if (stat.mod_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold the result until the output register is free
                if (out_free) begin
                    cmd         = CMD_EMIT;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_SEED_X;
        endcase
        if (cfg_wr) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SEED_X;
            pend_reg    <= 1'b0;
            pass_reg    <= 1'b0;
            seeding_reg <= 1'b0;
            mvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            pass_reg    <= pass_next;
            seeding_reg <= seeding_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// Bounded PCG32 generator testbench
// Sends raw, unsigned-range and signed-range requests under random idling on
// both streams and compares each result with an in-bench generator model.
// Walks several seeds, including both extremes, over the APB port.
// ---------------------------------------------------------------------------
module testbench;
    import pcg32b_pkg::*;

    localparam logic [63:0] LCG_MULT  = 64'd6364136223846793005;
    localparam logic [63:0] MIX_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL1  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL2  = 64'h94D0_49BB_1331_11EB;

    localparam logic [1:0] OP_SPARE   = 2'd3;   // unused code, acts as raw
    localparam logic [3:0] SEED_ADDR  = 4'd0;
    localparam logic [3:0] SPARE_ADDR = 4'd8;   // no register behind it

    localparam int NUM_SEEDS      = 6;
    localparam int REQS_PER_SEED  = 108;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] value;
        logic        bad;
    } result_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] lo;
        logic [31:0] hi;
        logic        typed_exp;
        logic [31:0] value;
        logic        bad;
    } sample_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [63:0] pwdata   = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // [31:0] low_bound, [63:32] high_bound
    logic [1:0]  s_tuser  = '0;   // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] value
    logic        m_tuser;         // [0] bad_range

    pcg32_bounded_random_generator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Generator model
    // -----------------------------------------------------------------------
    logic [63:0] seed_reg;
    logic [63:0] gen_state;
    logic [63:0] gen_inc;

    result_t     pending_results[$];
    sample_row_t directed_rows[$];

    int err_count = 0;
    int n_raw = 0, n_urange = 0, n_srange = 0, n_empty = 0, n_seeds = 0;
    int send_burst = 0, recv_burst = 0;
    int stall_cycles = 0;

    function automatic logic [63:0] sm_mix(input logic [63:0] x);
        logic [63:0] z;
        z = (x ^ (x >> 30)) * MIX_MUL1;
        z = (z ^ (z >> 27)) * MIX_MUL2;
        return z ^ (z >> 31);
    endfunction

    // Advance the LCG and return the output permutation of the old state.
    function automatic logic [31:0] pcg_word();
        logic [63:0] old;
        logic [63:0] folded;
        logic [31:0] xs;
        logic [4:0]  rot;
        old       = gen_state;
        gen_state = old * LCG_MULT + gen_inc;
        folded    = (old >> 18) ^ old;
        xs        = folded[58:27];
        rot       = old[63:59];
        return (xs >> rot) | (xs << ((6'd32 - {1'b0, rot}) & 6'd31));
    endfunction

    function automatic void reseed_generator(input logic [63:0] s);
        logic [63:0] x;
        logic [63:0] start;
        logic [63:0] strm;
        x         = s + MIX_GAMMA;
        start     = sm_mix(x);
        x         = x + MIX_GAMMA;
        strm      = sm_mix(x);
        gen_state = '0;
        gen_inc   = {strm[62:0], 1'b1};
        void'(pcg_word());
        gen_state = gen_state + start;
        void'(pcg_word());
    endfunction

    // Reject draws below the threshold so the modulo stays unbiased.
    function automatic logic [31:0] draw_below(input logic [31:0] span);
        logic [31:0] limit;
        logic [31:0] r;
        limit = (32'd0 - span) % span;
        do
            r = pcg_word();
        while (r < limit);
        return r % span;
    endfunction

    function automatic result_t predict_result(input logic [1:0] op,
                                               input logic [31:0] lo,
                                               input logic [31:0] hi);
        result_t            r;
        logic signed [31:0] s_lo;
        logic signed [31:0] s_hi;
        r    = '0;
        s_lo = {{16{lo[15]}}, lo[15:0]};
        s_hi = {{16{hi[15]}}, hi[15:0]};
        case (op)
            OP_URANGE: begin
                if (lo < hi) r.value = lo + draw_below(hi - lo);
                else r.bad = 1'b1;
            end
            OP_SRANGE: begin
                if (s_lo < s_hi) r.value = s_lo + draw_below(s_hi - s_lo);
                else r.bad = 1'b1;
            end
            default: begin
                r.value = pcg_word();
            end
        endcase
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function automatic int idle_cycles(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(4, 24);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic void add_row(input logic [1:0] op, input logic [31:0] lo,
                                    input logic [31:0] hi, input logic typed_exp,
                                    input logic [31:0] value, input logic bad);
        directed_rows.push_back('{op, lo, hi, typed_exp, value, bad});
    endfunction

    function automatic void report_mismatch(input string field, input logic [63:0] exp_v,
                                            input logic [63:0] act_v);
        err_count++;
        $error("%s mismatch: expected %h, got %h", field, exp_v, act_v);
    endfunction

    task automatic random_request(output logic [1:0] op, output logic [31:0] lo,
                                  output logic [31:0] hi);
        int          pick;
        logic [31:0] a;
        logic [31:0] b;
        pick = $urandom_range(0, 99);
        a    = $urandom;
        b    = $urandom;
        lo   = a;
        hi   = b;
        if (pick < 30) begin
            op = OP_RAW;
        end else if (pick < 36) begin
            op = OP_SPARE;
        end else if (pick < 70) begin
            op = OP_URANGE;
            case ($urandom_range(0, 3))
                0: begin
                    lo = $urandom_range(0, 32'hFFFF_FFF0);
                    hi = lo + $urandom_range(1, 16);
                end
                1: begin
                    lo = (a < b) ? a : b;
                    hi = (a < b) ? b : a;
                end
                2: begin
                    hi = a - $urandom_range(0, 3);
                end
                default: begin
                    lo = $urandom_range(0, 255);
                    hi = lo + ($urandom_range(0, 1) ? 32'h8000_0001 : 32'hFFFF_FF00);
                end
            endcase
        end else begin
            op = OP_SRANGE;
            if ($urandom_range(0, 3) == 0)
                hi[15:0] = lo[15:0] + 16'($urandom_range(1, 8));
            else if ($urandom_range(0, 9) != 0 && $signed(a[15:0]) >= $signed(b[15:0])) begin
                lo[15:0] = b[15:0];
                hi[15:0] = a[15:0];
            end
        end
    endtask

    // Leaves s_tvalid high after the request is taken.
    task automatic send_request(input logic [1:0] op, input logic [31:0] lo,
                                input logic [31:0] hi, input logic typed_exp,
                                input logic [31:0] value, input logic bad);
        int      gap;
        result_t r;
        gap = idle_cycles(send_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {hi, lo};
        do
            @(posedge aclk);
        while (!s_tready);
        if (typed_exp) r = '{value, bad};
        else r = predict_result(op, lo, hi);
        pending_results.push_back(r);
        case (op)
            OP_URANGE: n_urange++;
            OP_SRANGE: n_srange++;
            default:   n_raw++;
        endcase
        if (r.bad) n_empty++;
    endtask

    // Drop valid and hold until every result is back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_check(input logic [3:0] addr, input logic [63:0] exp_v);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        if (prdata !== exp_v) report_mismatch("seed readback", exp_v, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_seed(input logic [63:0] value);
        apb_write(SEED_ADDR, value);
        seed_reg = value;
        reseed_generator(value);
        n_seeds++;
        apb_check(SEED_ADDR, value);
    endtask

    // -----------------------------------------------------------------------
    // Result side
    // -----------------------------------------------------------------------
    initial begin
        int gap;
        forever begin
            gap = idle_cycles(recv_burst);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do
                @(posedge aclk);
            while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                err_count++;
                $error("result with nothing pending: value %h, bad_range %b",
                       m_tdata, m_tuser);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata !== exp_r.value)
                    report_mismatch("value", 64'(exp_r.value), 64'(m_tdata));
                if (m_tuser !== exp_r.bad)
                    report_mismatch("bad_range", 64'(exp_r.bad), 64'(m_tuser));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        logic [1:0]  op;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [63:0] seed_plan[NUM_SEEDS];

        seed_plan[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        seed_plan[1] = 64'h0;
        seed_plan[2] = {$urandom, $urandom};
        seed_plan[3] = 64'h1;
        seed_plan[4] = 64'h8000_0000_0000_0000;
        seed_plan[5] = {$urandom, $urandom};

        // raw words, including the unused code and bounds that must be ignored
        add_row(OP_RAW,    32'h0,         32'h0,         1'b0, '0, 1'b0);
        add_row(OP_RAW,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
        add_row(OP_SPARE,  32'h1234_5678, 32'h0000_0001, 1'b0, '0, 1'b0);
        add_row(OP_SPARE,  32'hFFFF_FFFF, 32'h0,         1'b0, '0, 1'b0);
        // unsigned ranges
        add_row(OP_URANGE, 32'h0,         32'h1,         1'b0, '0, 1'b0);
        add_row(OP_URANGE, 32'h0,         32'hFFFF_FFFF, 1'b0, '0, 1'b0);
        add_row(OP_URANGE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
        add_row(OP_URANGE, 32'h0,         32'h8000_0001, 1'b0, '0, 1'b0);
        add_row(OP_URANGE, 32'd100,       32'd107,       1'b0, '0, 1'b0);
        // empty unsigned ranges
        add_row(OP_URANGE, 32'h0,         32'h0,         1'b1, '0, 1'b1);
        add_row(OP_URANGE, 32'd5,         32'd5,         1'b1, '0, 1'b1);
        add_row(OP_URANGE, 32'hFFFF_FFFF, 32'h0,         1'b1, '0, 1'b1);
        add_row(OP_URANGE, 32'd10,        32'd3,         1'b1, '0, 1'b1);
        // signed ranges; upper bound bits are don't-care
        add_row(OP_SRANGE, 32'h0000_8000, 32'h0000_7FFF, 1'b0, '0, 1'b0);
        add_row(OP_SRANGE, 32'h0000_FFFF, 32'h0000_0001, 1'b0, '0, 1'b0);
        add_row(OP_SRANGE, 32'hABCD_FFF0, 32'h1234_0010, 1'b0, '0, 1'b0);
        add_row(OP_SRANGE, 32'h0000_0000, 32'hFFFF_7FFF, 1'b0, '0, 1'b0);
        add_row(OP_SRANGE, 32'h5555_8000, 32'hAAAA_8001, 1'b0, '0, 1'b0);
        add_row(OP_SRANGE, 32'hFFFF_8000, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
        // empty signed ranges
        add_row(OP_SRANGE, 32'h0000_0001, 32'h0000_FFFF, 1'b1, '0, 1'b1);
        add_row(OP_SRANGE, 32'h0000_7FFF, 32'h0000_8000, 1'b1, '0, 1'b1);
        add_row(OP_SRANGE, 32'h1234_0005, 32'hFFFF_0005, 1'b1, '0, 1'b1);

        seed_reg = '0;
        reseed_generator(seed_reg);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].lo, directed_rows[i].hi,
                         directed_rows[i].typed_exp, directed_rows[i].value,
                         directed_rows[i].bad);

        for (int ph = 0; ph < NUM_SEEDS; ph++) begin
            drain_results();
            program_seed(seed_plan[ph]);
            if (ph == 2) begin
                // a write to an empty address must leave seed and state alone
                apb_write(SPARE_ADDR, {$urandom, $urandom});
                apb_check(SEED_ADDR, seed_reg);
            end
            repeat (REQS_PER_SEED) begin
                random_request(op, lo, hi);
                send_request(op, lo, hi, 1'b0, '0, 1'b0);
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);

        $display("Covered %0d raw, %0d unsigned-range and %0d signed-range requests",
                 n_raw, n_urange, n_srange);
        $display("(%0d empty ranges) across reset and %0d seed writes, %0d errors",
                 n_empty, n_seeds, err_count);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
